[rtl/bcdalu_pkg.sv]
// ----------------------------------------------------------------------------
// bcdalu_pkg
// Types and constants shared by the binary/BCD byte ALU.
// ----------------------------------------------------------------------------
package bcdalu_pkg;

    typedef enum logic [1:0] {
        CMD_ADC = 2'd0,
        CMD_SBC = 2'd1,
        CMD_CMP = 2'd2,
        CMD_LSR = 2'd3
    } t_cmd;

    localparam logic [7:0] LOW_FIX  = 8'h06;
    localparam logic [7:0] HIGH_FIX = 8'h60;
    localparam logic [7:0] BCD_MAX  = 8'h99;
    localparam logic [4:0] NIB_MAX  = 5'd9;

endpackage

[rtl/bcd_binary_alu_8bit.sv]
// ----------------------------------------------------------------------------
// bcd_binary_alu_8bit
// Byte ALU with add, subtract, compare and shift right, and BCD correction.
//
// Input channel i_valid/o_ready carries one command with its operands, carry
// and decimal flag. Output channel o_valid/i_ready carries the result byte
// and the carry, overflow, negative and zero flags; o_overflow_written is
// high when the command updates the overflow flag (add and subtract).
// Each transaction passes an input register, one level of adder and
// correction logic, and a result register; o_valid rises when the result
// register takes it. One transaction is accepted every cycle as long as the
// receiver takes results. When the receiver stalls, the result register
// holds its contents and the input register still takes one more
// transaction, so o_ready falls only when both stages are full. Reset
// empties both stages; no result is pending afterwards.
// ----------------------------------------------------------------------------
module bcd_binary_alu_8bit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  bcdalu_pkg::t_cmd  i_cmd,
    input  logic [7:0]        i_reg_value,
    input  logic [7:0]        i_operand,
    input  logic              i_carry_in,
    input  logic              i_decimal_mode,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_result,
    output logic              o_carry_out,
    output logic              o_overflow_out,
    output logic              o_overflow_written,
    output logic              o_negative_out,
    output logic              o_zero_out
);
    import bcdalu_pkg::*;

    logic       r_s1_valid;
    t_cmd       r_cmd;
    logic [7:0] r_a;
    logic [7:0] r_v;
    logic       r_c;
    logic       r_dec;

    logic       r_out_valid;
    logic [7:0] r_result;
    logic       r_carry;
    logic       r_ovf;
    logic       r_ovf_wr;
    logic       r_neg;
    logic       r_zero;

    logic       s1_adv;
    logic       in_ready;

    logic [8:0] sum9;
    logic [4:0] low_add;
    logic [9:0] add_s1;
    logic [9:0] add_s2;
    logic       borrow;
    logic [8:0] diff9;
    logic       sub_low;
    logic       sub_hi;
    logic [7:0] sub_res;
    logic [8:0] cmp9;
    logic [7:0] flag_src;

    logic [7:0] n_result;
    logic       n_carry;
    logic       n_ovf;
    logic       n_ovf_wr;

    assign s1_adv   = !r_out_valid || i_ready;
    assign in_ready = !r_s1_valid || s1_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= i_valid;
        end
        if (in_ready) begin
            r_cmd <= i_cmd;
            r_a   <= i_reg_value;
            r_v   <= i_operand;
            r_c   <= i_carry_in;
            r_dec <= i_decimal_mode;
        end
    end

    always_comb begin
        sum9    = {1'b0, r_a} + {1'b0, r_v} + {8'd0, r_c};
        low_add = {1'b0, r_a[3:0]} + {1'b0, r_v[3:0]} + {4'd0, r_c};
        add_s1  = {1'b0, sum9}
                + ((r_dec && (low_add > NIB_MAX)) ? {2'b00, LOW_FIX} : 10'd0);
        add_s2  = add_s1
                + ((r_dec && (add_s1 > {2'b00, BCD_MAX})) ? {2'b00, HIGH_FIX} : 10'd0);

        borrow  = ~r_c;
        diff9   = {1'b0, r_a} - {1'b0, r_v} - {8'd0, borrow};
        sub_low = {1'b0, r_a[3:0]} < ({1'b0, r_v[3:0]} + {4'd0, borrow});
        sub_hi  = diff9[8] || (diff9[7:0] > BCD_MAX);
        sub_res = diff9[7:0]
                - ((r_dec && sub_low) ? LOW_FIX : 8'd0)
                - ((r_dec && sub_hi) ? HIGH_FIX : 8'd0);

        cmp9    = {1'b0, r_a} - {1'b0, r_v};

        unique case (r_cmd)
            CMD_ADC: begin
                n_result = add_s2[7:0];
                n_carry  = add_s2[9:8] != 2'b00;
                n_ovf    = (~(r_a[7] ^ r_v[7])) & (r_a[7] ^ sum9[7]);
                n_ovf_wr = 1'b1;
                flag_src = add_s2[7:0];
            end
            CMD_SBC: begin
                n_result = sub_res;
                n_carry  = !diff9[8];
                n_ovf    = (r_a[7] ^ r_v[7]) & (r_a[7] ^ diff9[7]);
                n_ovf_wr = 1'b1;
                flag_src = sub_res;
            end
            CMD_CMP: begin
                n_result = r_a;
                n_carry  = !cmp9[8];
                n_ovf    = 1'b0;
                n_ovf_wr = 1'b0;
                flag_src = cmp9[7:0];
            end
            CMD_LSR: begin
                n_result = {1'b0, r_v[7:1]};
                n_carry  = r_v[0];
                n_ovf    = 1'b0;
                n_ovf_wr = 1'b0;
                flag_src = {1'b0, r_v[7:1]};
            end
            default: begin
                n_result = r_a;
                n_carry  = 1'b0;
                n_ovf    = 1'b0;
                n_ovf_wr = 1'b0;
                flag_src = r_a;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
        if (s1_adv) begin
            r_result <= n_result;
            r_carry  <= n_carry;
            r_ovf    <= n_ovf;
            r_ovf_wr <= n_ovf_wr;
            r_neg    <= flag_src[7];
            r_zero   <= flag_src == 8'd0;
        end
    end

    assign o_ready            = in_ready;
    assign o_valid            = r_out_valid;
    assign o_result           = r_result;
    assign o_carry_out        = r_carry;
    assign o_overflow_out     = r_ovf;
    assign o_overflow_written = r_ovf_wr;
    assign o_negative_out     = r_neg;
    assign o_zero_out         = r_zero;

endmodule

[rtl/bcdalu_chk.sv]
// ----------------------------------------------------------------------------
// bcdalu_chk
// Port-level checks for the binary/BCD byte ALU, bound to the top level.
// ----------------------------------------------------------------------------
module bcdalu_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_result,
    input logic       o_overflow_out,
    input logic       o_overflow_written,
    input logic       o_zero_out
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result))
        else $error("stalled result changed");

    // no result pending after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // overflow only reported by commands that write it
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_overflow_written |-> !o_overflow_out)
        else $error("overflow set by compare or shift");

    // add and subtract take zero from the result byte
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow_written |-> o_zero_out == (o_result == 8'd0))
        else $error("zero flag disagrees with result");

endmodule

bind bcd_binary_alu_8bit bcdalu_chk u_bcdalu_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_result           (o_result),
    .o_overflow_out     (o_overflow_out),
    .o_overflow_written (o_overflow_written),
    .o_zero_out         (o_zero_out)
);

[bench/tb_bcd_binary_alu_8bit.sv]
// ----------------------------------------------------------------------------
// tb_bcd_binary_alu_8bit
// Self-checking bench for the binary/BCD byte ALU. A short directed table
// covers the operand extremes, every command, overflow, and the nibble and
// high BCD corrections for add and subtract. Random commands follow, half of
// them with valid BCD operands. Every result is compared field by field with
// typed values or a local predictor; handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_bcd_binary_alu_8bit;

    import bcdalu_pkg::*;

    localparam int  RANDOM_ITEMS = 1500;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam bit  PREDICT      = 1'b0;
    localparam bit  FIXED        = 1'b1;

    typedef struct packed {
        logic [7:0] result;
        logic       carry;
        logic       overflow;
        logic       ovf_written;
        logic       negative;
        logic       zero;
    } t_alu_flags;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] reg_value;
        logic [7:0] operand;
        logic       carry_in;
        logic       decimal_mode;
    } t_alu_op;

    typedef struct packed {
        t_alu_op    op;
        bit         fixed;
        t_alu_flags want;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_cmd       i_cmd;
    logic [7:0] i_reg_value;
    logic [7:0] i_operand;
    logic       i_carry_in;
    logic       i_decimal_mode;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_result;
    logic       o_carry_out;
    logic       o_overflow_out;
    logic       o_overflow_written;
    logic       o_negative_out;
    logic       o_zero_out;

    t_alu_flags expected_results[$];
    t_alu_flags head_result;
    int         error_count = 0;
    int         cycle_count = 0;
    bit         quiet = 1'b0;

    // expected values typed in only where obvious
    t_stim_row directed_rows [25] = '{
        '{'{CMD_ADC, 8'h00, 8'h00, 1'b0, 1'b0}, FIXED, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{'{CMD_ADC, 8'hFF, 8'h01, 1'b0, 1'b0}, FIXED, '{8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{'{CMD_ADC, 8'h7F, 8'h01, 1'b0, 1'b0}, FIXED, '{8'h80, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0}},
        '{'{CMD_ADC, 8'hFF, 8'hFF, 1'b1, 1'b0}, FIXED, '{8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{'{CMD_ADC, 8'h80, 8'h80, 1'b0, 1'b0}, FIXED, '{8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}},
        '{'{CMD_ADC, 8'h09, 8'h01, 1'b0, 1'b1}, PREDICT, '0},
        '{'{CMD_ADC, 8'h99, 8'h01, 1'b0, 1'b1}, PREDICT, '0},
        '{'{CMD_ADC, 8'h50, 8'h50, 1'b0, 1'b1}, PREDICT, '0},
        '{'{CMD_ADC, 8'h99, 8'h99, 1'b1, 1'b1}, PREDICT, '0},
        '{'{CMD_ADC, 8'h45, 8'h54, 1'b1, 1'b1}, PREDICT, '0},
        '{'{CMD_ADC, 8'hFF, 8'hFF, 1'b1, 1'b1}, PREDICT, '0},
        '{'{CMD_SBC, 8'h00, 8'h00, 1'b1, 1'b0}, FIXED, '{8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{'{CMD_SBC, 8'h00, 8'h01, 1'b1, 1'b0}, FIXED, '{8'hFF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{'{CMD_SBC, 8'h80, 8'h01, 1'b1, 1'b0}, FIXED, '{8'h7F, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{'{CMD_SBC, 8'h00, 8'h00, 1'b0, 1'b0}, FIXED, '{8'hFF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{'{CMD_SBC, 8'h10, 8'h01, 1'b1, 1'b1}, PREDICT, '0},
        '{'{CMD_SBC, 8'h00, 8'h01, 1'b1, 1'b1}, PREDICT, '0},
        '{'{CMD_SBC, 8'h00, 8'h00, 1'b0, 1'b1}, PREDICT, '0},
        '{'{CMD_SBC, 8'h99, 8'h99, 1'b1, 1'b1}, PREDICT, '0},
        '{'{CMD_SBC, 8'hFF, 8'hFF, 1'b0, 1'b1}, PREDICT, '0},
        '{'{CMD_CMP, 8'h42, 8'h42, 1'b0, 1'b0}, FIXED, '{8'h42, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{'{CMD_CMP, 8'h00, 8'hFF, 1'b1, 1'b1}, FIXED, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{CMD_CMP, 8'hFF, 8'h00, 1'b1, 1'b1}, FIXED, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{'{CMD_LSR, 8'h00, 8'h01, 1'b0, 1'b0}, FIXED, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{'{CMD_LSR, 8'h55, 8'hFF, 1'b1, 1'b1}, FIXED, '{8'h7F, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}}
    };

    bcd_binary_alu_8bit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_cmd              (i_cmd),
        .i_reg_value        (i_reg_value),
        .i_operand          (i_operand),
        .i_carry_in         (i_carry_in),
        .i_decimal_mode     (i_decimal_mode),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_result           (o_result),
        .o_carry_out        (o_carry_out),
        .o_overflow_out     (o_overflow_out),
        .o_overflow_written (o_overflow_written),
        .o_negative_out     (o_negative_out),
        .o_zero_out         (o_zero_out)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic t_alu_flags alu_outcome(t_alu_op op);
        int         a;
        int         v;
        int         c;
        int         borrow;
        int         total;
        int         diff;
        logic [7:0] flag_src;
        t_alu_flags f;
        a = op.reg_value;
        v = op.operand;
        c = op.carry_in;
        f = '0;
        case (op.cmd)
            CMD_ADC: begin
                total = a + v + c;
                f.overflow = ((~(a ^ v)) & (a ^ total) & 'h80) != 0;
                f.ovf_written = 1'b1;
                if (op.decimal_mode) begin
                    if ((a & 'hf) + (v & 'hf) + c > int'(NIB_MAX)) total += int'(LOW_FIX);
                    if (total > int'(BCD_MAX)) total += int'(HIGH_FIX);
                end
                f.carry = total > 'hff;
                f.result = total[7:0];
                flag_src = f.result;
            end
            CMD_SBC: begin
                borrow = c ? 0 : 1;
                diff = a - v - borrow;
                total = diff;
                f.carry = diff >= 0;
                f.overflow = ((a ^ v) & (a ^ diff) & 'h80) != 0;
                f.ovf_written = 1'b1;
                if (op.decimal_mode) begin
                    if ((a & 'hf) < (v & 'hf) + borrow) total -= int'(LOW_FIX);
                    // a wrapped difference counts as above the bcd range
                    if (diff < 0 || diff > int'(BCD_MAX)) total -= int'(HIGH_FIX);
                end
                f.result = total[7:0];
                flag_src = f.result;
            end
            CMD_CMP: begin
                diff = a - v;
                f.carry = a >= v;
                f.result = op.reg_value;
                flag_src = diff[7:0];
            end
            default: begin
                f.carry = op.operand[0];
                f.result = op.operand >> 1;
                flag_src = f.result;
            end
        endcase
        f.negative = flag_src[7];
        f.zero = (flag_src == 8'h00);
        return f;
    endfunction

    function automatic logic [7:0] bcd_byte();
        logic [3:0] hi;
        logic [3:0] lo;
        hi = 4'($urandom_range(0, 9));
        lo = 4'($urandom_range(0, 9));
        return {hi, lo};
    endfunction

    function automatic int idle_cycles();
        if (quiet || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    task automatic send_op(t_alu_op op, t_alu_flags want);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= op.cmd;
        i_reg_value    <= op.reg_value;
        i_operand      <= op.operand;
        i_carry_in     <= op.carry_in;
        i_decimal_mode <= op.decimal_mode;
        do @(posedge i_clk); while (!o_ready);
        expected_results.push_back(want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing expected");
                error_count++;
            end else begin
                head_result = expected_results.pop_front();
                check_field("result", head_result.result, o_result);
                check_field("carry_out", head_result.carry, o_carry_out);
                check_field("overflow_out", head_result.overflow, o_overflow_out);
                check_field("overflow_written", head_result.ovf_written, o_overflow_written);
                check_field("negative_out", head_result.negative, o_negative_out);
                check_field("zero_out", head_result.zero, o_zero_out);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stall before each transaction
    initial begin
        int stall;
        i_ready <= 1'b0;
        wait (i_rst_n == 1'b1);
        forever begin
            stall = idle_cycles();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        t_alu_op op;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_cmd          <= CMD_ADC;
        i_reg_value    <= 8'h00;
        i_operand      <= 8'h00;
        i_carry_in     <= 1'b0;
        i_decimal_mode <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_op(directed_rows[i].op,
                    directed_rows[i].fixed ? directed_rows[i].want
                                           : alu_outcome(directed_rows[i].op));
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
            op.cmd          = t_cmd'($urandom_range(0, 3));
            op.carry_in     = 1'($urandom_range(0, 1));
            op.decimal_mode = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 1) == 1) begin
                op.reg_value = bcd_byte();
                op.operand   = bcd_byte();
            end else begin
                op.reg_value = 8'($urandom);
                op.operand   = 8'($urandom);
            end
            send_op(op, alu_outcome(op));
        end
        i_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
